/* sv/wfbp_pkg.sv */
// Shared types and constants for the worst-fit bin packer.
// No dependencies; imported by every module of the block.
package wfbp_pkg;

    localparam int          DEF_MAX_BINS  = 256;
    localparam int          DEF_SIZE_BITS = 16;
    localparam int          QUEUE_DEPTH   = 2;
    localparam logic [15:0] CAP_RESET     = 16'd3600;

    localparam logic FUNC_PLACE = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Queued item: classified request plus raw size.
    typedef struct packed {
        logic        is_clear;
        logic [15:0] size;
    } t_item;

    // One result item as seen on the output channel.
    typedef struct packed {
        logic [7:0]  bin_index;
        logic        new_bin;
        logic [15:0] remaining_after;
        logic        oversize;
        logic        no_room;
        logic [8:0]  bins_in_use;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_eng_state;

endpackage

/* sv/wfbp_front.sv */
// Front end: accepts and classifies items into a short queue.
// Depends on wfbp_pkg.
module wfbp_front
    import wfbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [15:0] i_item_size,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             full, push, pop;

    assign full      = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_stall   = full;
    assign push      = i_valid && !full;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr].is_clear <= (i_func == FUNC_CLEAR);
            r_mem[r_wr_ptr].size     <= i_item_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* sv/wfbp_engine.sv */
// Back end: scans the bin table in memory, picks the worst-fit bin,
// writes it back and holds the result register. Depends on wfbp_pkg.
module wfbp_engine
    import wfbp_pkg::*;
#(
    parameter int MAX_BINS  = DEF_MAX_BINS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_cap,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_res_valid,
    output t_result     o_res,
    input  logic        i_res_stall
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    logic [SIZE_BITS-1:0] r_mem [MAX_BINS];

    t_eng_state           r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic [SIZE_BITS-1:0] r_size;
    logic [IDX_W-1:0]     r_rd_addr;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic                 r_cmp_valid;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best;
    logic [SIZE_BITS-1:0] r_best_rem;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 start, rd_en, last_addr, better;
    logic [SIZE_BITS-1:0] cap, q_size, fit_rem, new_rem;
    logic                 ovs;

    assign cap       = SIZE_BITS'(i_cap);
    assign q_size    = SIZE_BITS'(i_q_item.size);
    assign ovs       = (r_size > cap);
    assign last_addr = (r_rd_addr == IDX_W'(r_count - 1'b1));
    assign fit_rem   = r_best_rem - r_size;
    assign new_rem   = ovs ? '0 : (cap - r_size);
    assign better    = (r_rd_data >= r_size) && (!r_found || (r_rd_data > r_best_rem));

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_q_pop     = start;

    always_comb begin
        n_state = r_state;
        start   = 1'b0;
        rd_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    start = 1'b1;
                    if (!i_q_item.is_clear) begin
                        n_state = (r_count == '0) ? S_DECIDE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_en = 1'b1;
                if (last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_DECIDE;
            S_DECIDE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Table memory: one read port for the scan, one write at decision time.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
        if (r_state == S_DECIDE) begin
            if (r_found) begin
                r_mem[r_best] <= fit_rem;
            end else if (r_count < CNT_W'(MAX_BINS)) begin
                r_mem[IDX_W'(r_count)] <= new_rem;
            end
        end
    end

    // Scan datapath
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_addr;
        if (start) begin
            r_size    <= q_size;
            r_rd_addr <= '0;
        end else if (rd_en) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
        if (start) begin
            r_found <= 1'b0;
        end else if (r_cmp_valid && better) begin
            r_found    <= 1'b1;
            r_best     <= r_cmp_idx;
            r_best_rem <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_valid <= rd_en;
            if (r_out_valid && !i_res_stall) begin
                r_out_valid <= 1'b0;
            end
            if (start && i_q_item.is_clear) begin
                r_count     <= '0;
                r_out_valid <= 1'b1;
            end else if (r_state == S_DECIDE) begin
                r_out_valid <= 1'b1;
                if (!r_found && (r_count < CNT_W'(MAX_BINS))) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (start && i_q_item.is_clear) begin
            r_out <= '0;
        end else if (r_state == S_DECIDE) begin
            r_out.oversize <= ovs;
            if (r_found) begin
                r_out.bin_index       <= 8'(r_best);
                r_out.new_bin         <= 1'b0;
                r_out.remaining_after <= 16'(fit_rem);
                r_out.no_room         <= 1'b0;
                r_out.bins_in_use     <= 9'(r_count);
            end else if (r_count < CNT_W'(MAX_BINS)) begin
                r_out.bin_index       <= 8'(r_count);
                r_out.new_bin         <= 1'b1;
                r_out.remaining_after <= 16'(new_rem);
                r_out.no_room         <= 1'b0;
                r_out.bins_in_use     <= 9'(r_count + 1'b1);
            end else begin
                r_out.bin_index       <= '0;
                r_out.new_bin         <= 1'b0;
                r_out.remaining_after <= '0;
                r_out.no_room         <= 1'b1;
                r_out.bins_in_use     <= 9'(r_count);
            end
        end
    end

endmodule

/* sv/worst_fit_bin_packer.sv */
// Top level of the worst-fit bin packer: capacity register, front queue
// and scan engine. Depends on wfbp_pkg, wfbp_front and wfbp_engine.
//
// Usage:
//   Input channel (i_valid / o_stall) takes items: i_func = 0 places an
//   item of i_item_size, i_func = 1 clears all bins. Output channel
//   (o_valid / i_stall) returns one result item per input item, in order.
//   i_cfg_wr_en writes the bin capacity from i_cfg_wr_data; write only
//   while the block is idle.
// Sequence:
//   A place item goes through queue pop, one read per open bin, read pipe
//   drain, and decide and write back; with no bin open it goes from the
//   pop straight to decide. A clear is handled at the queue pop. The next
//   item starts only after the result is taken.
//   The input queue holds two items, so items keep being accepted while
//   the engine works or a result waits.
// Reset: bin count goes to zero, capacity to 3600, queue and result empty.
//   Bin table contents are not cleared.
// Stall: the result register holds; the engine waits, then the queue
//   fills and o_stall rises.
module worst_fit_bin_packer
    import wfbp_pkg::*;
#(
    parameter int MAX_BINS  = DEF_MAX_BINS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [15:0] i_item_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_bin_index,
    output logic        o_new_bin,
    output logic [15:0] o_remaining_after,
    output logic        o_oversize,
    output logic        o_no_room,
    output logic [8:0]  o_bins_in_use
);

    logic [15:0] r_cap;
    logic        q_valid, q_pop;
    t_item       q_item;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    wfbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_item_size (i_item_size),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    wfbp_engine #(
        .MAX_BINS  (MAX_BINS),
        .SIZE_BITS (SIZE_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_res_valid (o_valid),
        .o_res       (res),
        .i_res_stall (i_stall)
    );

    assign o_bin_index       = res.bin_index;
    assign o_new_bin         = res.new_bin;
    assign o_remaining_after = res.remaining_after;
    assign o_oversize        = res.oversize;
    assign o_no_room         = res.no_room;
    assign o_bins_in_use     = res.bins_in_use;

endmodule
